>>> rtl/core/tlam_pkg.sv
// shared types, constants and the lfo rom builder for the tremolo modulator
// no dependencies; imported by tlam_ctrl, tlam_datapath and the top level
package tlam_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int PHASE_WIDTH = 24;
   // table depth is taken to be a power of two
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SINE_ADDR_WIDTH = $clog2(SINE_TABLE_DEPTH);

   localparam int STEP_WIDTH = 23;
   localparam int DEPTH_WIDTH = 16;
   localparam int LFO_WIDTH = 16;
   localparam int GAIN_WIDTH = 16;
   localparam int GAIN_FRAC = 15;
   localparam int PROD_WIDTH = SAMPLE_WIDTH + GAIN_WIDTH + 1;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [STEP_WIDTH-1:0] STEP_RESET = STEP_WIDTH'(699);
   localparam logic [DEPTH_WIDTH-1:0] DEPTH_ONE = DEPTH_WIDTH'(32768);
   localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = GAIN_WIDTH'(32768);
   localparam logic [2*LFO_WIDTH:0] LFO_ROUND = (2*LFO_WIDTH+1)'(32768);
   localparam logic signed [PROD_WIDTH-1:0] OUT_ROUND = PROD_WIDTH'(16384);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PHASE_STEP,
      CSR_MOD_DEPTH
   } csr_index_type;

   typedef struct packed {
      logic accept;
      logic rom_read;
      logic gain_load;
      logic prod_load;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

   typedef logic [LFO_WIDTH-1:0] lfo_rom_type [SINE_TABLE_DEPTH];

   localparam logic [63:0] Q30_TWO_PI = 64'd6746518852;
   localparam logic [63:0] Q30_PI = 64'd3373259426;
   localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

   // taylor series to x^13 in q30, truncating products
   function automatic logic [63:0] quarter_sine(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t1, t2, t3, t4, t5, t6;
      logic [63:0] pos, neg;
      x2 = (x * x) >> 30;
      t1 = ((x * x2) >> 30) / 6;
      t2 = ((t1 * x2) >> 30) / 20;
      t3 = ((t2 * x2) >> 30) / 42;
      t4 = ((t3 * x2) >> 30) / 72;
      t5 = ((t4 * x2) >> 30) / 110;
      t6 = ((t5 * x2) >> 30) / 156;
      pos = x + t2 + t4 + t6;
      neg = t1 + t3 + t5;
      return (neg > pos) ? 64'd0 : pos - neg;
   endfunction

   // q0.16 value of 0.5 + 0.5*sin at angle 2*pi*k/depth
   function automatic logic [LFO_WIDTH-1:0] lfo_entry(input logic [63:0] k);
      logic [63:0] x;
      logic [63:0] mag;
      logic [63:0] v;
      logic negative;
      x = (k * Q30_TWO_PI + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
      negative = 1'b0;
      if (x > Q30_PI) begin
         x = x - Q30_PI;
         negative = 1'b1;
      end
      if (x > Q30_HALF_PI) begin
         x = (x > Q30_PI) ? 64'd0 : Q30_PI - x;
      end
      mag = (quarter_sine(x) + 64'd16384) >> 15;
      if (mag > 64'd32768) begin
         mag = 64'd32768;
      end
      v = negative ? 64'd32768 - mag : 64'd32768 + mag;
      if (v > 64'd65535) begin
         v = 64'd65535;
      end
      return v[LFO_WIDTH-1:0];
   endfunction

   function automatic lfo_rom_type build_lfo_rom();
      lfo_rom_type rom;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         rom[k] = lfo_entry(64'(k));
      end
      return rom;
   endfunction

endpackage

>>> rtl/core/tlam_ctrl.sv
// sequencing state machine for the tremolo modulator
// depends on tlam_pkg for the command and status structs
module tlam_ctrl
   import tlam_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROM,
      ST_GAIN,
      ST_MUL,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = ST_ROM;
            end
         end
         ST_ROM: begin
            cmd.rom_read = 1'b1;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.gain_load = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.prod_load = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded while output register still full");

   a_accept_then_rom: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> cmd.rom_read)
      else $error("rom read did not follow accepted transfer");

   a_gain_then_prod: assert property (@(posedge clock) disable iff (reset)
      cmd.gain_load |=> cmd.prod_load)
      else $error("sample multiply did not follow gain load");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.rom_read, cmd.gain_load, cmd.prod_load, cmd.out_load}))
      else $error("more than one datapath command at once");
`endif

endmodule

>>> rtl/core/tlam_datapath.sv
// datapath: phase accumulator, lfo rom, gain and sample multiplies, output register
// depends on tlam_pkg for widths, constants, command structs and the rom builder
module tlam_datapath
   import tlam_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  ctrl_cmd_type                   cmd,
   output dp_status_type                  status,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   input  logic [STEP_WIDTH-1:0]          step,
   input  logic [DEPTH_WIDTH-1:0]         depth,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out
);

   localparam lfo_rom_type LFO_ROM = build_lfo_rom();

   logic [PHASE_WIDTH-1:0]          phase_ff, phase_in;
   logic [STEP_WIDTH+PHASE_WIDTH-1:0] step_wide;
   logic [SINE_ADDR_WIDTH-1:0]      addr_ff;
   logic signed [SAMPLE_WIDTH-1:0]  sample_ff;
   logic [LFO_WIDTH-1:0]            lfo_ff;
   logic [GAIN_WIDTH-1:0]           gain_ff, gain_in;
   logic [2*LFO_WIDTH-1:0]          depth_lfo;
   logic [2*LFO_WIDTH:0]            lfo_scaled;
   logic signed [GAIN_WIDTH:0]      gain_signed;
   logic signed [PROD_WIDTH-1:0]    prod_ff, prod_in;
   logic signed [PROD_WIDTH-1:0]    rounded;
   logic signed [SAMPLE_WIDTH-1:0]  out_ff;
   logic                            valid_ff;

   // step masked or extended to the phase width
   assign step_wide = {{PHASE_WIDTH{1'b0}}, step};
   assign phase_in = phase_ff + step_wide[PHASE_WIDTH-1:0];

   // full-width depth times lfo product
   assign depth_lfo = depth * lfo_ff;
   assign lfo_scaled = {1'b0, depth_lfo} + LFO_ROUND;
   assign gain_in = GAIN_ONE - lfo_scaled[2*LFO_WIDTH-1:LFO_WIDTH];

   assign gain_signed = {1'b0, gain_ff};
   assign prod_in = sample_ff * gain_signed;
   assign rounded = prod_ff + OUT_ROUND;

   assign status.out_free = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            phase_ff <= phase_in;
         end
         if (cmd.out_load) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample_in;
         addr_ff <= phase_ff[PHASE_WIDTH-1 -: SINE_ADDR_WIDTH];
      end
      if (cmd.rom_read) begin
         lfo_ff <= LFO_ROM[addr_ff];
      end
      if (cmd.gain_load) begin
         gain_ff <= gain_in;
      end
      if (cmd.prod_load) begin
         prod_ff <= prod_in;
      end
      if (cmd.out_load) begin
         out_ff <= rounded[GAIN_FRAC+SAMPLE_WIDTH-1:GAIN_FRAC];
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_sample_out = out_ff;

endmodule

>>> rtl/core/tremolo_lfo_amplitude_modulator.sv
// tremolo: sample scaled by 1 - depth*(0.5+0.5*sin(2*pi*phase)), phase from a 24-bit accumulator
// rsp_valid rises after an accepted req transfer when the output is free, once the controller
// has walked through rom read, gain multiply, sample multiply and rounding; a new req is taken
//    only back in idle, so one item is in flight at a time, all on one shared datapath
// reset (synchronous): phase to zero, phase_step 699, mod_depth 1.0, no result pending
// depends on tlam_pkg, tlam_ctrl and tlam_datapath
module tremolo_lfo_amplitude_modulator
   import tlam_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,

   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]      csr_wdata
);

   // config registers
   logic [STEP_WIDTH-1:0]  step_ff;
   logic [DEPTH_WIDTH-1:0] depth_ff;
   logic [DEPTH_WIDTH-1:0] depth_in;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // writes are always taken unchecked; the sender must issue them only while the block is idle
   assign csr_ready = 1'b1;

   // depth above one saturates to one at write time
   assign depth_in = (csr_wdata[DEPTH_WIDTH-1:0] > DEPTH_ONE) ?
                     DEPTH_ONE : csr_wdata[DEPTH_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
         depth_ff <= DEPTH_ONE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PHASE_STEP: begin
               step_ff <= csr_wdata[STEP_WIDTH-1:0];
            end
            CSR_MOD_DEPTH: begin
               depth_ff <= depth_in;
            end
            default: begin
               // indexes past the register list are ignored
            end
         endcase
      end
   end

   // sequencer: one item in flight, stalls before the output register when it is full
   tlam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // phase accumulator, rom, multiplies and the output register
   tlam_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample_in  (req_sample_in),
      .step           (step_ff),
      .depth          (depth_ff),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule
